/* rtl/osp_pkg.sv */
// Shared constants, command codes and payload types of the one-shot sample player.
package osp_pkg;

   localparam int TABLE_DEPTH   = 65536;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int ROW_W         = IDX_W - 1;
   localparam int ROWS          = TABLE_DEPTH / 2;
   localparam int PHASE_W       = 32;
   localparam int INC_W         = 20;
   localparam int LEN_W         = 17;
   localparam int SAMPLE_W      = 16;
   localparam int FRAC_ONE      = 2 ** FRACTION_BITS;
   localparam int MIN_INCREMENT = (FRAC_ONE + 999) / 1000;
   localparam int END_W         = IDX_W + FRACTION_BITS;
   localparam int CMP_W         = ((END_W > PHASE_W) ? END_W : PHASE_W) + 1;
   localparam int PROD_W        = SAMPLE_W + 1 + FRACTION_BITS + 1;
   localparam int CSR_AW        = 5;
   localparam int CSR_DW        = 32;
   localparam int LEN_RESET     = 65536;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_TRIGGER = 2'd1,
      CMD_STOP    = 2'd2,
      CMD_WRITE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_TABLE_LENGTH    = 3'd0,
      REG_START_POSITION  = 3'd1,
      REG_FIRST_LENGTH    = 3'd2,
      REG_FIRST_INCREMENT = 3'd3,
      REG_LAST_INCREMENT  = 3'd4
   } reg_type;

   typedef struct packed {
      cmd_type                     command;
      logic [15:0]                 sample_index;
      logic signed [SAMPLE_W-1:0]  sample_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       playing;
   } rsp_type;

   // Configuration as seen by the phase stage, with end position precomputed
   typedef struct packed {
      logic [IDX_W-1:0]   last_idx;
      logic [PHASE_W-1:0] end_pos;
      logic               end_big;
      logic [PHASE_W-1:0] start_position;
      logic [PHASE_W-1:0] first_length;
      logic [INC_W-1:0]   first_increment;
      logic [INC_W-1:0]   last_increment;
   } cfg_type;

   // Control that travels alongside the table read
   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic                     playing;
      logic                     swap;
      logic [FRACTION_BITS-1:0] frac;
   } rd_ctl_type;

   typedef struct packed {
      logic                       we;
      logic                       wr_bank;
      logic [ROW_W-1:0]           wr_row;
      logic signed [SAMPLE_W-1:0] wr_data;
      logic [ROW_W-1:0]           even_row;
      logic [ROW_W-1:0]           odd_row;
   } tbl_cmd_type;

endpackage

/* rtl/osp_csr.sv */
// Configuration register file with APB-style access and derived end position.
module osp_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [osp_pkg::CSR_AW-1:0] paddr,
   input  logic [osp_pkg::CSR_DW-1:0] pwdata,
   output logic [osp_pkg::CSR_DW-1:0] prdata,
   output logic                      pready,
   output osp_pkg::cfg_type          cfg
);
   import osp_pkg::*;

   localparam int LC_W = IDX_W + 1;
   localparam logic [CMP_W-1:0] PHASE_MAX_C = CMP_W'({PHASE_W{1'b1}});

   logic [LEN_W-1:0]   table_length_ff, table_length_in;
   logic [IDX_W-1:0]   last_idx_ff, last_idx_in;
   logic [PHASE_W-1:0] end_pos_ff, end_pos_in;
   logic               end_big_ff, end_big_in;
   logic [PHASE_W-1:0] start_ff, start_in;
   logic [PHASE_W-1:0] first_len_ff, first_len_in;
   logic [INC_W-1:0]   first_inc_ff, first_inc_in;
   logic [INC_W-1:0]   last_inc_ff, last_inc_in;
   logic               wr;
   reg_type            reg_sel;

   function automatic logic [IDX_W-1:0] last_of(input logic [LEN_W-1:0] tl);
      logic [LC_W-1:0] len;
      if (32'(tl) < 2) begin
         len = LC_W'(2);
      end else if (32'(tl) > TABLE_DEPTH) begin
         len = LC_W'(TABLE_DEPTH);
      end else begin
         len = LC_W'(tl);
      end
      return IDX_W'(len - LC_W'(2));
   endfunction

   function automatic logic [PHASE_W:0] end_of(input logic [IDX_W-1:0] last);
      logic [END_W-1:0] full;
      logic             big;
      full = END_W'(last) << FRACTION_BITS;
      big  = CMP_W'(full) > PHASE_MAX_C;
      return {big, big ? {PHASE_W{1'b1}} : PHASE_W'(full)};
   endfunction

   function automatic logic [INC_W-1:0] clamp_inc(input logic [INC_W-1:0] v);
      return (32'(v) < MIN_INCREMENT) ? INC_W'(MIN_INCREMENT) : v;
   endfunction

   assign wr      = psel && penable && pwrite;
   assign reg_sel = reg_type'(paddr[CSR_AW-1:2]);
   assign pready  = 1'b1;

   always_comb begin
      table_length_in = table_length_ff;
      last_idx_in     = last_idx_ff;
      end_big_in      = end_big_ff;
      end_pos_in      = end_pos_ff;
      start_in        = start_ff;
      first_len_in    = first_len_ff;
      first_inc_in    = first_inc_ff;
      last_inc_in     = last_inc_ff;
      if (wr) begin
         case (reg_sel)
            REG_TABLE_LENGTH: begin
               table_length_in          = pwdata[LEN_W-1:0];
               last_idx_in              = last_of(pwdata[LEN_W-1:0]);
               {end_big_in, end_pos_in} = end_of(last_of(pwdata[LEN_W-1:0]));
            end
            REG_START_POSITION:  start_in     = pwdata[PHASE_W-1:0];
            REG_FIRST_LENGTH:    first_len_in = pwdata[PHASE_W-1:0];
            REG_FIRST_INCREMENT: first_inc_in = clamp_inc(pwdata[INC_W-1:0]);
            REG_LAST_INCREMENT:  last_inc_in  = clamp_inc(pwdata[INC_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff          <= LEN_W'(LEN_RESET);
         last_idx_ff              <= last_of(LEN_W'(LEN_RESET));
         {end_big_ff, end_pos_ff} <= end_of(last_of(LEN_W'(LEN_RESET)));
         start_ff                 <= '0;
         first_len_ff             <= '0;
         first_inc_ff             <= clamp_inc(INC_W'(FRAC_ONE));
         last_inc_ff              <= INC_W'(MIN_INCREMENT);
      end else begin
         table_length_ff <= table_length_in;
         last_idx_ff     <= last_idx_in;
         end_big_ff      <= end_big_in;
         end_pos_ff      <= end_pos_in;
         start_ff        <= start_in;
         first_len_ff    <= first_len_in;
         first_inc_ff    <= first_inc_in;
         last_inc_ff     <= last_inc_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TABLE_LENGTH:    prdata = CSR_DW'(table_length_ff);
         REG_START_POSITION:  prdata = CSR_DW'(start_ff);
         REG_FIRST_LENGTH:    prdata = CSR_DW'(first_len_ff);
         REG_FIRST_INCREMENT: prdata = CSR_DW'(first_inc_ff);
         REG_LAST_INCREMENT:  prdata = CSR_DW'(last_inc_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg.last_idx        = last_idx_ff;
   assign cfg.end_pos         = end_pos_ff;
   assign cfg.end_big         = end_big_ff;
   assign cfg.start_position  = start_ff;
   assign cfg.first_length    = first_len_ff;
   assign cfg.first_increment = first_inc_ff;
   assign cfg.last_increment  = last_inc_ff;

endmodule

/* rtl/osp_phase.sv */
// Command decode, phase accumulator and table address generation.
module osp_phase (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 adv,
   input  osp_pkg::req_type     req,
   input  osp_pkg::cfg_type     cfg,
   output osp_pkg::tbl_cmd_type tbl,
   output osp_pkg::rd_ctl_type  s1
);
   import osp_pkg::*;

   localparam int IP_W = PHASE_W - FRACTION_BITS;

   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic                     active_ff, active_in;
   rd_ctl_type               s1_ff, s1_in;
   logic [INC_W-1:0]         inc;
   logic [PHASE_W:0]         sum;
   logic                     past_end;
   logic [PHASE_W-1:0]       tick_phase;
   logic [IP_W-1:0]          idx_raw;
   logic                     over;
   logic [IDX_W-1:0]         rd_idx;
   logic [FRACTION_BITS-1:0] frac;
   logic [IDX_W-1:0]         wr_addr;

   always_comb begin
      inc        = (phase_ff > cfg.first_length) ? cfg.last_increment : cfg.first_increment;
      sum        = {1'b0, phase_ff} + (PHASE_W+1)'(inc);
      past_end   = !cfg.end_big && (phase_ff > cfg.end_pos);
      // clamp at end, saturate on overflow
      tick_phase = past_end ? cfg.end_pos :
                   (sum[PHASE_W] ? {PHASE_W{1'b1}} : sum[PHASE_W-1:0]);
      idx_raw    = tick_phase[PHASE_W-1:FRACTION_BITS];
      over       = CMP_W'(idx_raw) > CMP_W'(cfg.last_idx);
      rd_idx     = over ? cfg.last_idx : IDX_W'(idx_raw);
      frac       = over ? {FRACTION_BITS{1'b1}} : tick_phase[FRACTION_BITS-1:0];
   end

   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      if (accept) begin
         case (req.command)
            CMD_TICK: begin
               if (active_ff) begin
                  phase_in  = tick_phase;
                  active_in = !past_end;
               end
            end
            CMD_TRIGGER: begin
               phase_in  = cfg.start_position;
               active_in = 1'b1;
            end
            CMD_STOP: begin
               phase_in  = '0;
               active_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_in.valid   = accept && (req.command == CMD_TICK);
      s1_in.zero    = !active_ff;
      s1_in.playing = active_ff && !past_end;
      s1_in.swap    = rd_idx[0];
      s1_in.frac    = frac;
   end

   // idx and idx+1 always fall in opposite banks
   assign wr_addr      = IDX_W'(req.sample_index);
   assign tbl.we       = accept && (req.command == CMD_WRITE) &&
                         (32'(req.sample_index) < TABLE_DEPTH);
   assign tbl.wr_bank  = wr_addr[0];
   assign tbl.wr_row   = wr_addr[IDX_W-1:1];
   assign tbl.wr_data  = req.sample_value;
   assign tbl.odd_row  = rd_idx[IDX_W-1:1];
   assign tbl.even_row = rd_idx[IDX_W-1:1] + ROW_W'(rd_idx[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         active_ff <= 1'b0;
         s1_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
         if (adv) begin
            s1_ff <= s1_in;
         end
      end
   end

   assign s1 = s1_ff;

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req.command == CMD_STOP) |=> !active_ff && (phase_ff == '0))
      else $error("stop did not clear phase and active");

   a_trigger_loads: assert property (@(posedge clock) disable iff (reset)
      accept && (req.command == CMD_TRIGGER)
      |=> active_ff && (phase_ff == $past(cfg.start_position)))
      else $error("trigger did not load start position");

   a_end_clamps: assert property (@(posedge clock) disable iff (reset)
      accept && (req.command == CMD_TICK) && active_ff && past_end
      |=> !active_ff && (phase_ff == $past(cfg.end_pos)))
      else $error("end of table did not stop playback");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.zero |-> !s1_ff.playing)
      else $error("idle tick marked as playing");

endmodule

/* rtl/osp_table.sv */
// Sample table split into even and odd banks, one read port each.
module osp_table (
   input  logic                                   clock,
   input  logic                                   rd_en,
   input  osp_pkg::tbl_cmd_type                   tbl,
   output logic signed [osp_pkg::SAMPLE_W-1:0]    even_q,
   output logic signed [osp_pkg::SAMPLE_W-1:0]    odd_q
);
   import osp_pkg::*;

   logic signed [SAMPLE_W-1:0] even_mem [ROWS];
   logic signed [SAMPLE_W-1:0] odd_mem  [ROWS];
   logic signed [SAMPLE_W-1:0] even_q_ff;
   logic signed [SAMPLE_W-1:0] odd_q_ff;

   always_ff @(posedge clock) begin
      if (tbl.we && !tbl.wr_bank) begin
         even_mem[tbl.wr_row] <= tbl.wr_data;
      end
      if (rd_en) begin
         even_q_ff <= even_mem[tbl.even_row];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl.we && tbl.wr_bank) begin
         odd_mem[tbl.wr_row] <= tbl.wr_data;
      end
      if (rd_en) begin
         odd_q_ff <= odd_mem[tbl.odd_row];
      end
   end

   assign even_q = even_q_ff;
   assign odd_q  = odd_q_ff;

endmodule

/* rtl/osp_interp.sv */
// Linear interpolation between neighboring samples and the output register.
module osp_interp (
   input  logic                                clock,
   input  logic                                reset,
   input  osp_pkg::rd_ctl_type                 s1,
   input  logic signed [osp_pkg::SAMPLE_W-1:0] even_q,
   input  logic signed [osp_pkg::SAMPLE_W-1:0] odd_q,
   input  logic                                rsp_stall,
   output logic                                adv,
   output logic                                rsp_valid,
   output osp_pkg::rsp_type                    rsp_data
);
   import osp_pkg::*;

   logic signed [SAMPLE_W-1:0] a_c;
   logic signed [SAMPLE_W-1:0] b_c;
   logic signed [SAMPLE_W:0]   diff_c;
   logic signed [PROD_W-1:0]   prod_c;
   logic                       v2_ff;
   logic                       zero2_ff;
   logic                       playing2_ff;
   logic signed [SAMPLE_W-1:0] a2_ff;
   logic signed [PROD_W-1:0]   prod2_ff;
   logic signed [PROD_W-1:0]   sum_c;
   rsp_type                    out_in;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      a_c    = s1.swap ? odd_q : even_q;
      b_c    = s1.swap ? even_q : odd_q;
      diff_c = (SAMPLE_W+1)'(b_c) - (SAMPLE_W+1)'(a_c);
      prod_c = PROD_W'(diff_c) * PROD_W'($signed({1'b0, s1.frac}));
   end

   // arithmetic shift floors toward minus infinity
   always_comb begin
      sum_c              = PROD_W'(a2_ff) + (prod2_ff >>> FRACTION_BITS);
      out_in.sample_out  = zero2_ff ? '0 : sum_c[SAMPLE_W-1:0];
      out_in.playing     = playing2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v2_ff        <= s1.valid;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero2_ff    <= s1.zero;
         playing2_ff <= s1.playing;
         a2_ff       <= a_c;
         prod2_ff    <= prod_c;
         rsp_data_ff <= out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/one_shot_sample_player.sv */
// One-shot sample player: the result of an accepted tick is registered once in each stage below.
// Throughput one item per cycle; stages: phase add with table read, multiply, final add.
// All stages advance together and hold while the output register is full and stalled.
// Reset clears phase, playback flag, pipeline valids and restores configuration defaults.
// The sample table is not cleared by reset; write entries before playing them.
module one_shot_sample_player (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  osp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output osp_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [osp_pkg::CSR_AW-1:0] paddr,
   input  logic [osp_pkg::CSR_DW-1:0] pwdata,
   output logic [osp_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import osp_pkg::*;

   cfg_type                    cfg;
   tbl_cmd_type                tbl;
   rd_ctl_type                 s1;
   logic                       adv;
   logic                       accept;
   logic signed [SAMPLE_W-1:0] even_q;
   logic signed [SAMPLE_W-1:0] odd_q;

   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   osp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   osp_phase u_phase (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .adv    (adv),
      .req    (req_data),
      .cfg    (cfg),
      .tbl    (tbl),
      .s1     (s1)
   );

   osp_table u_table (
      .clock  (clock),
      .rd_en  (adv),
      .tbl    (tbl),
      .even_q (even_q),
      .odd_q  (odd_q)
   );

   osp_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .s1        (s1),
      .even_q    (even_q),
      .odd_q     (odd_q),
      .rsp_stall (rsp_stall),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/one_shot_sample_player_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the one-shot sample player: predicts and checks every tick result.
module one_shot_sample_player_tb;
   import osp_pkg::*;

   localparam longint PHASE_MAX      = 64'hFFFF_FFFF;
   localparam int     DRAIN_CYCLES   = 8;
   localparam int     LONG_HOLD      = 400;
   localparam int     WATCHDOG_LIMIT = 3000;
   localparam int     RUN_ITEMS      = 1800;
   localparam int     RUN_PHASES     = 12;
   localparam int     PRINT_CAP      = 100;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [CSR_AW-1:0]   paddr     = '0;
   logic [CSR_DW-1:0]   pwdata    = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // Register copies as the player uses them
   longint len_reg   = LEN_RESET;
   longint start_pos = 0;
   longint first_len = 0;
   longint first_inc = FRAC_ONE;
   longint last_inc  = MIN_INCREMENT;

   // Playhead and sample table copies
   longint             play_phase = 0;
   bit                 play_on    = 1'b0;
   logic signed [15:0] wave   [TABLE_DEPTH];
   bit                 loaded [TABLE_DEPTH];

   rsp_type expected_samples[$];

   int  items_sent      = 0;
   int  results_checked = 0;
   int  mismatches      = 0;
   int  reg_writes      = 0;
   int  runouts         = 0;
   int  holds_asked     = 0;
   int  holds_served    = 0;
   int  hold_left       = 0;
   int  pattern_left    = 0;
   int  stall_style     = 0;
   int  quiet_cycles    = 0;
   int  burst_left      = 0;
   bit  gapless         = 1'b0;

   one_shot_sample_player uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
   endtask

   function automatic longint clamp_step(logic [INC_W-1:0] v);
      return (v < MIN_INCREMENT) ? MIN_INCREMENT : v;
   endfunction

   function automatic longint eff_len();
      if (len_reg < 2) return 2;
      if (len_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return len_reg;
   endfunction

   // Advance a playhead by one tick; gives the table pair and fraction it reads
   function automatic void step_playhead(inout longint ph, inout bit on,
                                         output int unsigned at, output int unsigned frac);
      longint last_at;
      longint end_pos;
      last_at = eff_len() - 2;
      end_pos = last_at << FRACTION_BITS;
      if (ph > end_pos) begin
         ph = end_pos;
         on = 1'b0;
      end else begin
         ph += (ph > first_len) ? last_inc : first_inc;
         if (ph > PHASE_MAX) ph = PHASE_MAX;
      end
      at   = ph >> FRACTION_BITS;
      frac = ph & (FRAC_ONE - 1);
      if (at > last_at) begin
         at   = last_at;
         frac = FRAC_ONE - 1;
      end
   endfunction

   function automatic rsp_type predict_tick();
      rsp_type     r;
      int unsigned at, frac;
      longint      a, b;
      r = '0;
      if (play_on) begin
         step_playhead(play_phase, play_on, at, frac);
         if (!play_on) runouts++;
         a = wave[at];
         b = wave[at + 1];
         r.sample_out = a + (((b - a) * longint'(frac)) >>> FRACTION_BITS);
         r.playing    = play_on;
      end
      return r;
   endfunction

   function automatic req_type make_item(cmd_type c, logic [15:0] at, logic [15:0] v);
      req_type it;
      it.command      = c;
      it.sample_index = at;
      it.sample_value = v;
      return it;
   endfunction

   task automatic pace();
      if (gapless) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clock);
      burst_left = $urandom_range(0, 24);
   endtask

   task automatic send_item(input req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      case (it.command)
         CMD_TRIGGER: begin
            play_on    = 1'b1;
            play_phase = start_pos;
         end
         CMD_STOP: begin
            play_on    = 1'b0;
            play_phase = 0;
         end
         CMD_WRITE: begin
            wave[it.sample_index]   = it.sample_value;
            loaded[it.sample_index] = 1'b1;
         end
         default: expected_samples.push_back(predict_tick());
      endcase
      pace();
   endtask

   // Fill any table pair the next tick reads that holds no sample yet
   task automatic send_tick();
      longint      ph;
      bit          on;
      int unsigned at, frac;
      ph = play_phase;
      on = play_on;
      if (on) begin
         step_playhead(ph, on, at, frac);
         for (int k = 0; k < 2; k++)
            if (!loaded[at + k])
               send_item(make_item(CMD_WRITE, at + k, $urandom_range(0, 65535)));
      end
      send_item(make_item(CMD_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535)));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_type r, input logic [31:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      reg_writes++;
      case (r)
         REG_TABLE_LENGTH:    len_reg   = v[LEN_W-1:0];
         REG_START_POSITION:  start_pos = v;
         REG_FIRST_LENGTH:    first_len = v;
         REG_FIRST_INCREMENT: first_inc = clamp_step(v[INC_W-1:0]);
         REG_LAST_INCREMENT:  last_inc  = clamp_step(v[INC_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_playback(input logic [31:0] len, input logic [31:0] start,
                               input logic [31:0] flen, input logic [31:0] finc,
                               input logic [31:0] linc);
      wait_drain();
      write_reg(REG_TABLE_LENGTH, len);
      write_reg(REG_START_POSITION, start);
      write_reg(REG_FIRST_LENGTH, flen);
      write_reg(REG_FIRST_INCREMENT, finc);
      write_reg(REG_LAST_INCREMENT, linc);
   endtask

   function automatic logic [31:0] pick_step();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return $urandom_range('h2000, 'h30000);
      if (roll < 15) return $urandom_range(0, 80);
      return $urandom_range(0, 'hFFFFF);
   endfunction

   task automatic test_idle_and_defaults();
      send_tick();
      send_item(make_item(CMD_TRIGGER, 0, 0));
      // whole-sample first step, then minimum steps past the first segment
      repeat (3) send_tick();
      send_item(make_item(CMD_STOP, 16'hFFFF, 16'hFFFF));
      send_tick();
   endtask

   task automatic test_short_table();
      // length below two and zero increments both clamp
      set_playback(1, 0, 0, 0, 0);
      send_item(make_item(CMD_WRITE, 0, 16'h8000));
      send_item(make_item(CMD_WRITE, 1, 16'h7FFF));
      send_item(make_item(CMD_TRIGGER, 0, 0));
      repeat (3) send_tick();
      wait_drain();
      write_reg(REG_FIRST_INCREMENT, 'hFFFFF);
      send_item(make_item(CMD_TRIGGER, 0, 0));
      repeat (3) send_tick();
   endtask

   task automatic test_phase_saturation();
      // start beyond the end position stops on the first tick
      set_playback('h1FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFFF, 'hFFFFF);
      send_item(make_item(CMD_TRIGGER, 0, 0));
      repeat (2) send_tick();
      wait_drain();
      // start at the end position: the add saturates and the read clamps
      write_reg(REG_START_POSITION, 'hFFFE_0000);
      send_item(make_item(CMD_WRITE, 16'hFFFF, 16'h8000));
      send_item(make_item(CMD_TRIGGER, 0, 0));
      repeat (3) send_tick();
   endtask

   task automatic test_output_hold();
      set_playback(40, 0, 10 << FRACTION_BITS, 'h8000, 'h3000);
      gapless = 1'b1;
      holds_asked++;
      send_item(make_item(CMD_TRIGGER, 0, 0));
      repeat (60) send_tick();
      wait_drain();
      gapless = 1'b0;
   endtask

   task automatic test_random_play();
      int unsigned span, end_pos, back, len_val, start_val, flen_val, roll;
      int          stop_at, run_len;
      cmd_type     cmd;
      for (int p = 0; p < RUN_PHASES; p++) begin
         wait_drain();
         gapless = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 9);
         if (p == 0) len_val = 2;
         else if (p == 1) len_val = TABLE_DEPTH;
         else if (roll < 7) len_val = $urandom_range(2, 48);
         else if (roll == 7) len_val = $urandom_range(0, 1);
         else if (roll == 8) len_val = $urandom_range(TABLE_DEPTH, 131071);
         else len_val = $urandom_range(49, TABLE_DEPTH);
         write_reg(REG_TABLE_LENGTH, len_val);
         span    = eff_len();
         end_pos = (span - 2) << FRACTION_BITS;
         back    = $urandom_range(0, 'h40000);
         roll    = $urandom_range(0, 19);
         if (p == 1 || (roll >= 14 && roll < 17)) start_val = (end_pos > back) ? end_pos - back : 0;
         else if (roll < 14) start_val = $urandom_range(0, (span - 1) << FRACTION_BITS);
         else start_val = $urandom();
         flen_val = ($urandom_range(0, 4) != 0) ?
                    $urandom_range(0, (span - 1) << FRACTION_BITS) : $urandom();
         write_reg(REG_START_POSITION, start_val);
         write_reg(REG_FIRST_LENGTH, flen_val);
         write_reg(REG_FIRST_INCREMENT, (p == 0) ? 'hFFFFF : pick_step());
         write_reg(REG_LAST_INCREMENT, (p == 0) ? 0 : pick_step());

         stop_at = items_sent + RUN_ITEMS / RUN_PHASES;
         while (items_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               send_item(make_item(CMD_TRIGGER, $urandom_range(0, 65535), $urandom_range(0, 65535)));
               run_len = $urandom_range(1, 60);
               repeat (run_len) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 4)
                     send_item(make_item(CMD_WRITE, $urandom_range(0, span - 1),
                                         $urandom_range(0, 65535)));
                  else if (roll < 6)
                     send_item(make_item(CMD_STOP, 0, 0));
                  else if (roll < 8)
                     send_item(make_item(CMD_TRIGGER, 0, 0));
                  send_tick();
               end
            end else if (roll < 85) begin
               repeat ($urandom_range(1, 6))
                  send_item(make_item(CMD_WRITE,
                                      $urandom_range(0, 1) ? $urandom_range(0, span - 1) :
                                                             $urandom_range(0, 65535),
                                      $urandom_range(0, 65535)));
            end else if (roll < 92) begin
               send_item(make_item(CMD_STOP, $urandom_range(0, 65535), $urandom_range(0, 65535)));
               repeat ($urandom_range(1, 4)) send_tick();
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  cmd = cmd_type'($urandom_range(0, 3));
                  if (cmd == CMD_TICK) send_tick();
                  else send_item(make_item(cmd, $urandom_range(0, 65535), $urandom_range(0, 65535)));
               end
            end
         end
      end
   endtask

   // Output side: a long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_stall    <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_style  <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(50, 300);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            2:       rsp_stall <= ((pattern_left % 8) < 5);
            default: rsp_stall <= ($urandom_range(0, 99) < 80);
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected result sample %0d playing %0b",
                                      rsp_data.sample_out, rsp_data.playing));
         end else begin
            want = expected_samples.pop_front();
            results_checked++;
            if (rsp_data.sample_out !== want.sample_out)
               report_mismatch($sformatf("result %0d: sample %0d, want %0d", results_checked,
                                         rsp_data.sample_out, want.sample_out));
            if (rsp_data.playing !== want.playing)
               report_mismatch($sformatf("result %0d: playing %0b, want %0b", results_checked,
                                         rsp_data.playing, want.playing));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without progress, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_samples.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_and_defaults();
      test_short_table();
      test_phase_saturation();
      test_output_hold();
      test_random_play();
      wait_drain();
      $display("Sent %0d items, checked %0d tick results, made %0d register writes.",
               items_sent, results_checked, reg_writes);
      $display("%0d playbacks ran off the table end; %0d long output hold-offs.",
               runouts, holds_asked);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
